// ===== hdl/pft_pkg.sv =====
// Package for the polygon fan triangulator.
// Holds the widths, the edge flag and input kind codes, and the queue word type.
// No dependencies; every module of the block imports it.
package pft_pkg;

    localparam int INDEX_BITS     = 24;
    localparam int SIZE_BITS      = 8;
    localparam int COUNT_BITS     = 24;
    localparam int MIN_FACE_VERTS = 3;
    localparam int MAX_FACE_VERTS = 255;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    typedef logic [INDEX_BITS-1:0] index_t;
    typedef logic [SIZE_BITS-1:0]  size_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_VERTEX = 1'b1;

    typedef enum logic [1:0] {
        EDGE_PLAIN  = 2'd0,
        EDGE_FIRST  = 2'd1,
        EDGE_LAST   = 2'd2,
        EDGE_MIDDLE = 2'd3
    } edge_flag_t;

    // One triangle as classified by the front end, before winding.
    typedef struct packed {
        index_t     anchor;
        index_t     prior;
        index_t     current;
        count_t     face;
        edge_flag_t flag;
        logic       last;
    } tri_cmd_t;

endpackage

// ===== hdl/polygon_fan_triangulator.sv =====
// Polygon fan triangulator, top level: front end, triangle queue, back end.
// Depends on pft_pkg, pft_front, pft_queue and pft_back.
//
// Takes one word per clock: a face header (vertex count, hole mark) or one vertex index of
// the current face. From the third vertex of a face that is not a hole and has at least
// three vertices, each vertex yields one fan triangle, which passes through the triangle
// queue and the result register, numbered by face and by a running triangle count. The input
// stalls only when the four-entry triangle queue is full, so with the result side ready
// the block sustains one word per cycle; the result side is held in a register of its own.
// flip_winding is written over the cfg port and reverses the winding from then on; the user
// must write it only while no words are in flight, as the block itself does not enforce it.
module polygon_fan_triangulator import pft_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_kind,
    input  index_t     s_vertex_index,
    input  size_t      s_face_size,
    input  logic       s_is_hole,
    output logic       m_valid,
    input  logic       m_ready,
    output index_t     m_corner_a,
    output index_t     m_corner_b,
    output index_t     m_corner_c,
    output count_t     m_face_number,
    output edge_flag_t m_edge_flag,
    output count_t     m_triangle_number,
    output logic       m_last_of_face,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_flip_winding
);

    logic     push_valid;
    logic     push_ready;
    tri_cmd_t push_data;
    logic     pop_valid;
    logic     pop_ready;
    tri_cmd_t pop_data;

    pft_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_vertex_index (s_vertex_index),
        .s_face_size    (s_face_size),
        .s_is_hole      (s_is_hole),
        .cmd_valid      (push_valid),
        .cmd_ready      (push_ready),
        .cmd            (push_data)
    );

    pft_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    pft_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_flip_winding  (cfg_flip_winding),
        .pop_valid         (pop_valid),
        .pop_ready         (pop_ready),
        .pop_data          (pop_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_corner_a        (m_corner_a),
        .m_corner_b        (m_corner_b),
        .m_corner_c        (m_corner_c),
        .m_face_number     (m_face_number),
        .m_edge_flag       (m_edge_flag),
        .m_triangle_number (m_triangle_number),
        .m_last_of_face    (m_last_of_face)
    );

endmodule

// ===== hdl/pft_front.sv =====
// Front end of the fan triangulator: accepts header and vertex words, tracks the face.
// Pushes one classified triangle per emitting vertex into the queue.
// Depends on pft_pkg.
module pft_front import pft_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic     s_kind,
    input  index_t   s_vertex_index,
    input  size_t    s_face_size,
    input  logic     s_is_hole,
    output logic     cmd_valid,
    input  logic     cmd_ready,
    output tri_cmd_t cmd
);

    count_t next_face_reg,    next_face_next;
    count_t current_face_reg, current_face_next;
    size_t  held_size_reg,    held_size_next;
    size_t  position_reg,     position_next;
    logic   skip_face_reg,    skip_face_next;
    index_t anchor_reg,       anchor_next;
    index_t prior_reg,        prior_next;

    logic accept;
    logic vertex_live;
    logic emit;

    assign s_ready     = cmd_ready;
    assign accept      = s_valid && s_ready;
    assign vertex_live = (s_kind == KIND_VERTEX) && !skip_face_reg
                         && (position_reg < held_size_reg);
    assign emit        = vertex_live && (position_reg >= SIZE_BITS'(2));
    assign cmd_valid   = s_valid && emit;

    always_comb begin
        cmd.anchor  = anchor_reg;
        cmd.prior   = prior_reg;
        cmd.current = s_vertex_index;
        cmd.face    = current_face_reg;
        cmd.last    = (position_reg == held_size_reg - SIZE_BITS'(1));
        if (held_size_reg > SIZE_BITS'(MIN_FACE_VERTS)) begin
            if (position_reg == SIZE_BITS'(2)) begin
                cmd.flag = EDGE_FIRST;
            end else if (cmd.last) begin
                cmd.flag = EDGE_LAST;
            end else begin
                cmd.flag = EDGE_MIDDLE;
            end
        end else begin
            cmd.flag = EDGE_PLAIN;
        end
    end

    always_comb begin
        next_face_next    = next_face_reg;
        current_face_next = current_face_reg;
        held_size_next    = held_size_reg;
        position_next     = position_reg;
        skip_face_next    = skip_face_reg;
        anchor_next       = anchor_reg;
        prior_next        = prior_reg;
        if (accept) begin
            if (s_kind == KIND_HEADER) begin
                current_face_next = next_face_reg;
                next_face_next    = next_face_reg + COUNT_BITS'(1);
                held_size_next    = s_face_size;
                position_next     = '0;
                skip_face_next    = s_is_hole
                                    || (s_face_size < SIZE_BITS'(MIN_FACE_VERTS))
                                    || (int'(s_face_size) > MAX_FACE_VERTS);
            end else if (vertex_live) begin
                // first vertex anchors the fan, every later one becomes the prior
                if (position_reg == '0) begin
                    anchor_next = s_vertex_index;
                end else begin
                    prior_next = s_vertex_index;
                end
                position_next = position_reg + SIZE_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_face_reg    <= '0;
            current_face_reg <= '0;
            held_size_reg    <= '0;
            position_reg     <= '0;
            skip_face_reg    <= 1'b1;
        end else begin
            next_face_reg    <= next_face_next;
            current_face_reg <= current_face_next;
            held_size_reg    <= held_size_next;
            position_reg     <= position_next;
            skip_face_reg    <= skip_face_next;
        end
    end

    always_ff @(posedge aclk) begin
        anchor_reg <= anchor_next;
        prior_reg  <= prior_next;
    end

endmodule

// ===== hdl/pft_queue.sv =====
// Short register queue between the front end and the back end.
// Holds classified triangles so each side can stall on its own.
// Depends on pft_pkg.
module pft_queue import pft_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push_valid,
    output logic     push_ready,
    input  tri_cmd_t push_data,
    output logic     pop_valid,
    input  logic     pop_ready,
    output tri_cmd_t pop_data
);

    tri_cmd_t                  slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_BITS:0]   count_reg,  count_next;
    logic                      do_push;
    logic                      do_pop;

    assign push_ready = (count_reg != (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // depth is a power of two, so the pointers wrap on their own
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QUEUE_PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QUEUE_PTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + (QUEUE_PTR_BITS+1)'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - (QUEUE_PTR_BITS+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/pft_back.sv =====
// Back end of the fan triangulator: applies winding and rotation, numbers triangles.
// Holds the flip_winding register and the output register of the result channel.
// Depends on pft_pkg.
module pft_back import pft_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_flip_winding,
    input  logic       pop_valid,
    output logic       pop_ready,
    input  tri_cmd_t   pop_data,
    output logic       m_valid,
    input  logic       m_ready,
    output index_t     m_corner_a,
    output index_t     m_corner_b,
    output index_t     m_corner_c,
    output count_t     m_face_number,
    output edge_flag_t m_edge_flag,
    output count_t     m_triangle_number,
    output logic       m_last_of_face
);

    logic       flip_reg;
    logic       valid_reg,  valid_next;
    count_t     tri_count_reg, tri_count_next;
    index_t     corner_a_reg, corner_b_reg, corner_c_reg;
    count_t     face_reg, tri_num_reg;
    edge_flag_t flag_reg;
    logic       last_reg;
    index_t     a_w, b_w, c_w;
    logic       load;

    assign cfg_ready = 1'b1;
    assign pop_ready = !valid_reg || m_ready;
    assign load      = pop_valid && pop_ready;

    always_comb begin
        a_w = pop_data.anchor;
        b_w = pop_data.prior;
        c_w = pop_data.current;
        if (flip_reg) begin
            case (pop_data.flag)
                EDGE_FIRST: begin
                    a_w = pop_data.current;
                    b_w = pop_data.prior;
                    c_w = pop_data.anchor;
                end
                EDGE_LAST: begin
                    a_w = pop_data.prior;
                    b_w = pop_data.anchor;
                    c_w = pop_data.current;
                end
                default: begin
                    a_w = pop_data.anchor;
                    b_w = pop_data.current;
                    c_w = pop_data.prior;
                end
            endcase
        end
    end

    always_comb begin
        valid_next     = valid_reg;
        tri_count_next = tri_count_reg;
        if (load) begin
            valid_next     = 1'b1;
            tri_count_next = tri_count_reg + COUNT_BITS'(1);
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flip_reg      <= 1'b0;
            valid_reg     <= 1'b0;
            tri_count_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                flip_reg <= cfg_flip_winding;
            end
            valid_reg     <= valid_next;
            tri_count_reg <= tri_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            corner_a_reg <= a_w;
            corner_b_reg <= b_w;
            corner_c_reg <= c_w;
            face_reg     <= pop_data.face;
            flag_reg     <= pop_data.flag;
            tri_num_reg  <= tri_count_reg;
            last_reg     <= pop_data.last;
        end
    end

    assign m_valid           = valid_reg;
    assign m_corner_a        = corner_a_reg;
    assign m_corner_b        = corner_b_reg;
    assign m_corner_c        = corner_c_reg;
    assign m_face_number     = face_reg;
    assign m_edge_flag       = flag_reg;
    assign m_triangle_number = tri_num_reg;
    assign m_last_of_face    = last_reg;

endmodule

// ===== hdl/pft_checker.sv =====
// Port-level checks for the polygon fan triangulator, bound to the top level.
// Depends on pft_pkg and polygon_fan_triangulator.
module pft_checker import pft_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input index_t     m_corner_a,
    input index_t     m_corner_b,
    input index_t     m_corner_c,
    input edge_flag_t m_edge_flag,
    input count_t     m_triangle_number,
    input logic       m_last_of_face
);

    logic   seen_reg;
    count_t last_num_reg;

    // remember the number of the last word taken on the result side
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg     <= 1'b0;
            last_num_reg <= '0;
        end else if (m_valid && m_ready) begin
            seen_reg     <= 1'b1;
            last_num_reg <= m_triangle_number;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_corner_a) && $stable(m_corner_b)
            && $stable(m_corner_c) && $stable(m_triangle_number))
        else $error("result word changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_tri_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && seen_reg |-> m_triangle_number == last_num_reg + COUNT_BITS'(1))
        else $error("triangle number skipped or repeated");

    a_first_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_edge_flag == EDGE_FIRST |-> !m_last_of_face)
        else $error("first fan triangle marked last of face");

    a_single_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_edge_flag == EDGE_PLAIN || m_edge_flag == EDGE_LAST) |-> m_last_of_face)
        else $error("closing triangle not marked last of face");

endmodule

bind polygon_fan_triangulator pft_checker u_pft_checker (.*);

// ===== tb/testbench.sv =====
// Testbench for polygon_fan_triangulator: face headers and vertex words go in, fan triangles
// come out and are checked field by field against an in-bench fan predictor.
// Depends on pft_pkg and the polygon_fan_triangulator RTL.
module testbench;
    import pft_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_PERCENT = 31;

    typedef struct {
        index_t     a;
        index_t     b;
        index_t     c;
        count_t     face;
        edge_flag_t flag;
        count_t     number;
        logic       last;
    } triangle_t;

    logic       aclk;
    logic       aresetn          = 1'b0;
    logic       s_valid          = 1'b0;
    logic       s_ready;
    logic       s_kind           = KIND_HEADER;
    index_t     s_vertex_index   = '0;
    size_t      s_face_size      = '0;
    logic       s_is_hole        = 1'b0;
    logic       m_valid;
    logic       m_ready          = 1'b0;
    index_t     m_corner_a;
    index_t     m_corner_b;
    index_t     m_corner_c;
    count_t     m_face_number;
    edge_flag_t m_edge_flag;
    count_t     m_triangle_number;
    logic       m_last_of_face;
    logic       cfg_valid        = 1'b0;
    logic       cfg_ready;
    logic       cfg_flip_winding = 1'b0;

    // fan predictor state
    logic   flip_now;
    count_t face_next;
    count_t face_now;
    size_t  size_held;
    size_t  vert_pos;
    logic   face_skipped;
    index_t anchor_pt;
    index_t prior_pt;
    count_t tri_count;

    triangle_t pending_triangles[$];
    int        failures     = 0;
    int        cycle_count  = 0;
    bit        tx_idle_en   = 1'b1;
    bit        rx_idle_en   = 1'b1;
    bit        hold_request = 1'b0;
    int        hold_left    = 0;

    polygon_fan_triangulator uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_vertex_index    (s_vertex_index),
        .s_face_size       (s_face_size),
        .s_is_hole         (s_is_hole),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_corner_a        (m_corner_a),
        .m_corner_b        (m_corner_b),
        .m_corner_c        (m_corner_c),
        .m_face_number     (m_face_number),
        .m_edge_flag       (m_edge_flag),
        .m_triangle_number (m_triangle_number),
        .m_last_of_face    (m_last_of_face),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_flip_winding  (cfg_flip_winding)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Advance the fan state by one accepted word; return 1 when it yields a triangle.
    function automatic logic predict_fan(input logic kind, input index_t vtx, input size_t size,
                                         input logic hole, output triangle_t fan_tri);
        index_t t;
        int     j;
        fan_tri = '{default: '0, flag: EDGE_PLAIN};
        if (kind == KIND_HEADER) begin
            face_now     = face_next;
            face_next    = face_next + COUNT_BITS'(1);
            size_held    = size;
            vert_pos     = '0;
            face_skipped = hole || int'(size) < MIN_FACE_VERTS || int'(size) > MAX_FACE_VERTS;
            return 1'b0;
        end
        if (face_skipped || vert_pos >= size_held)
            return 1'b0;
        if (vert_pos == 0) begin
            anchor_pt = vtx;
            vert_pos  = SIZE_BITS'(1);
            return 1'b0;
        end
        if (vert_pos == 1) begin
            prior_pt = vtx;
            vert_pos = SIZE_BITS'(2);
            return 1'b0;
        end
        j = int'(vert_pos) - 2;
        fan_tri.a = anchor_pt;
        fan_tri.b = flip_now ? vtx : prior_pt;
        fan_tri.c = flip_now ? prior_pt : vtx;
        if (size_held > 3) begin
            if (j == 0) begin
                if (flip_now) begin
                    t = fan_tri.a; fan_tri.a = fan_tri.b; fan_tri.b = fan_tri.c; fan_tri.c = t;
                end
                fan_tri.flag = EDGE_FIRST;
            end else if (j == int'(size_held) - 3) begin
                if (flip_now) begin
                    t = fan_tri.c; fan_tri.c = fan_tri.b; fan_tri.b = fan_tri.a; fan_tri.a = t;
                end
                fan_tri.flag = EDGE_LAST;
            end else begin
                fan_tri.flag = EDGE_MIDDLE;
            end
        end
        fan_tri.face   = face_now;
        fan_tri.number = tri_count;
        fan_tri.last   = (int'(vert_pos) == int'(size_held) - 1);
        tri_count      = tri_count + COUNT_BITS'(1);
        prior_pt       = vtx;
        vert_pos       = vert_pos + SIZE_BITS'(1);
        return 1'b1;
    endfunction

    task automatic note_failure(input string what, input triangle_t want, input triangle_t got);
        failures++;
        if (failures <= 10)
            $display({"%s: expected a=%h b=%h c=%h face=%h flag=%0d num=%h last=%b, ",
                      "got a=%h b=%h c=%h face=%h flag=%0d num=%h last=%b"},
                     what, want.a, want.b, want.c, want.face, want.flag, want.number, want.last,
                     got.a, got.b, got.c, got.face, got.flag, got.number, got.last);
    endtask

    // check each result word, then predict from the accepted input word
    always @(posedge aclk) begin : fan_checker
        triangle_t got;
        triangle_t want;
        if (!aresetn) begin
            flip_now     = 1'b0;
            face_next    = '0;
            face_now     = '0;
            size_held    = '0;
            vert_pos     = '0;
            face_skipped = 1'b1;
            anchor_pt    = '0;
            prior_pt     = '0;
            tri_count    = '0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_corner_a, m_corner_b, m_corner_c, m_face_number, m_edge_flag,
                        m_triangle_number, m_last_of_face};
                if (pending_triangles.size() == 0) begin
                    want = '{default: '0, flag: EDGE_PLAIN};
                    note_failure("unexpected triangle", want, got);
                end else begin
                    want = pending_triangles.pop_front();
                    if (got.a !== want.a || got.b !== want.b || got.c !== want.c ||
                        got.face !== want.face || got.flag !== want.flag ||
                        got.number !== want.number || got.last !== want.last)
                        note_failure("triangle mismatch", want, got);
                end
            end
            if (cfg_valid && cfg_ready)
                flip_now = cfg_flip_winding;
            if (s_valid && s_ready) begin
                if (predict_fan(s_kind, s_vertex_index, s_face_size, s_is_hole, want))
                    pending_triangles.insert(pending_triangles.size(), want);
            end
        end
    end

    // result side: random stalls, plus a long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !rx_idle_en || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    function automatic index_t rand_index();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return index_t'($urandom);
        endcase
    endfunction

    // Offer one word and hold it until accepted; valid stays high for a back-to-back word.
    task automatic send_word(input logic kind, input index_t vtx, input size_t size,
                             input logic hole);
        if (tx_idle_en && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while (tx_idle_en && $urandom_range(99) < IDLE_PERCENT);
        end
        s_valid        <= 1'b1;
        s_kind         <= kind;
        s_vertex_index <= vtx;
        s_face_size    <= size;
        s_is_hole      <= hole;
        do @(posedge aclk); while (!s_ready);
    endtask

    // unused fields carry random junk so every input bit toggles
    task automatic send_header(input int size, input logic hole);
        send_word(KIND_HEADER, index_t'($urandom), size_t'(size), hole);
    endtask

    task automatic send_vertex(input index_t vtx);
        send_word(KIND_VERTEX, vtx, size_t'($urandom), 1'($urandom));
    endtask

    task automatic send_face(input int size, input logic hole, input int count);
        send_header(size, hole);
        repeat (count) send_vertex(rand_index());
    endtask

    // Drop valid and wait until every expected triangle is back, then let the pipe settle.
    task automatic drain(input int settle);
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_triangles.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_flip(input logic value);
        drain(10);
        cfg_flip_winding <= value;
        cfg_valid        <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        send_vertex('1);                  // stray vertex before any header
        send_header(0, 1'b0);
        send_vertex(24'h000001);
        send_header(2, 1'b0);             // degenerate face
        send_vertex(24'h000002);
        send_header(3, 1'b1);             // hole
        send_vertex(24'h000003);
        send_header(3, 1'b0);             // single plain triangle
        send_vertex('0);
        send_vertex('1);
        send_vertex(24'h123456);
        send_vertex(24'hABCDEF);          // surplus vertex
        send_header(5, 1'b0);             // first, middle, last
        send_vertex(24'h000010);
        send_vertex(24'h000011);
        send_vertex(24'h000012);
        send_vertex(24'h000013);
        send_vertex('1);
        write_flip(1'b1);
        send_header(4, 1'b0);             // flipped fan with rotated ends
        send_vertex(24'h000020);
        send_vertex(24'h000021);
        send_vertex(24'h000022);
        send_vertex(24'hFFFFFE);
    endtask

    // Mostly well-formed faces with random content; some broken, oversized or stray words.
    task automatic test_random_mesh(input int target);
        int   useful;
        int   size;
        int   count;
        int   pick;
        logic hole;
        useful = 0;
        while (useful < target) begin
            pick = $urandom_range(99);
            if (pick < 1)
                size = $urandom_range(11, 255);
            else if (pick < 10)
                size = $urandom_range(0, 2);
            else
                size = $urandom_range(3, 10);
            hole  = ($urandom_range(99) < 8);
            count = ($urandom_range(99) < 8) ? $urandom_range(0, size + 2) : size;
            send_face(size, hole, count);
            useful += 1;
            if (!hole && size >= MIN_FACE_VERTS)
                useful += (count < size) ? count : size;
            if ($urandom_range(99) < 5)
                send_vertex(rand_index());
        end
    endtask

    // Hold the result side off while a long face streams in, so the input stalls.
    task automatic test_backpressure();
        tx_idle_en   = 1'b0;
        hold_request = 1'b1;
        send_face(60, 1'b0, 60);
        tx_idle_en = 1'b1;
    endtask

    task automatic test_steady_stream(input int target);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_random_mesh(target);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    initial begin
        triangle_t none;
        none = '{default: '0, flag: EDGE_PLAIN};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        write_flip(1'b0);
        test_random_mesh(620);
        write_flip(1'b1);
        test_random_mesh(490);
        test_backpressure();
        test_steady_stream(270);
        write_flip(1'b0);
        test_random_mesh(220);

        drain(20);
        while (pending_triangles.size() != 0)
            note_failure("missing triangle", pending_triangles.pop_front(), none);
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
